// File: hdl/rtb_pkg.sv
// Package for the relocation table builder: word types, state types and constants.
`timescale 1ns / 1ps
`default_nettype none

package rtb_pkg;

    // Buffer size and reset position
    localparam int          TABLE_BYTES_DEF = 65536;
    localparam logic [16:0] WP_RESET        = 17'd8;
    localparam logic [15:0] START_LIMIT     = 16'hFFFF;

    // Type tags placed over the page offset of an entry
    localparam logic [15:0] TAG_NARROW = 16'h3000;
    localparam logic [15:0] TAG_WIDE   = 16'h8000;

    // Write lengths in bytes
    localparam logic [3:0] LEN_ENTRY  = 4'd2;
    localparam logic [3:0] LEN_DWORD  = 4'd4;
    localparam logic [3:0] LEN_HEADER = 4'd8;

    // Operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Configuration register indexes
    localparam logic [7:0] CFG_IMAGE_BASE = 8'd0;
    localparam logic [7:0] CFG_WIDE_MODE  = 8'd1;

    // Input word
    typedef struct packed {
        logic        operation;
        logic [63:0] target_address;
    } in_word_t;

    // Output word: one buffer write
    typedef struct packed {
        logic [15:0] write_offset;
        logic [31:0] write_data;
        logic        write_wide;
        logic [16:0] used_bytes;
        logic        overflow;
        logic        last;
    } out_word_t;

    // Table builder state
    typedef struct packed {
        logic [51:0] open_page;
        logic        block_open;
        logic [15:0] block_start;
        logic [16:0] write_position;
    } tbl_state_t;

    // Where the word in hand has got to
    typedef enum logic [1:0] {
        PH_START,
        PH_PATCH,
        PH_HDR,
        PH_ENTRY
    } phase_t;

    // Step control returned to the sequencer
    typedef struct packed {
        logic   has_result;
        logic   done;
        phase_t phase_next;
    } step_ctl_t;

endpackage

`default_nettype wire

// File: hdl/reloc_table_builder.sv
// Top level of the relocation table builder: input holding register, sequencer and output register.
// The first write of a word passes through the input holding register and then the output register.
// Throughput: one buffer write per cycle while the output register is free; a word makes one
// write for most adds and up to four on a page change, a finish with no open block makes none.
// The next word is taken in the cycle the current word's last write is registered.
// Reset (rst_n low, asynchronous) empties both registers, clears the configuration and
// returns the table state to no open block with the write position at 8.
`timescale 1ns / 1ps
`default_nettype none

module reloc_table_builder
    import rtb_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data
);

    localparam logic [16:0] TABLE_LIMIT = 17'(TABLE_BYTES);

    // Only the low dword of the image base reaches the page RVA
    logic [31:0] base_reg;
    logic        wide_reg;
    tbl_state_t  st_reg;
    tbl_state_t  st_next;
    phase_t      phase_reg;
    logic        hold_valid_reg;
    in_word_t    hold_reg;
    logic        out_valid_reg;
    out_word_t   out_reg;
    out_word_t   step_result;
    step_ctl_t   ctl;
    logic        slot_free;
    logic        go;
    logic        in_take;

    assign slot_free = !out_valid_reg || out_ready;
    assign go        = hold_valid_reg && slot_free;
    assign in_ready  = !hold_valid_reg || (slot_free && ctl.done);
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Step logic
    rtb_step #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_step (
        .state          (st_reg),
        .phase          (phase_reg),
        .item           (hold_reg),
        .image_base_low (base_reg),
        .wide_mode      (wide_reg),
        .state_next     (st_next),
        .result         (step_result),
        .ctl            (ctl)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            wide_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_IMAGE_BASE)
                base_reg <= cfg_data[31:0];
            else if (cfg_index == CFG_WIDE_MODE)
                wide_reg <= cfg_data[0];
        end
    end

    // Table state, phase and word flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.open_page      <= '0;
            st_reg.block_open     <= 1'b0;
            st_reg.block_start    <= '0;
            st_reg.write_position <= WP_RESET;
            phase_reg             <= PH_START;
            hold_valid_reg        <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                st_reg    <= st_next;
                phase_reg <= ctl.done ? PH_START : ctl.phase_next;
            end
            if (in_take)
                hold_valid_reg <= 1'b1;
            else if (go && ctl.done)
                hold_valid_reg <= 1'b0;
            if (go && ctl.has_result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            hold_reg <= in_data;
        if (go && ctl.has_result)
            out_reg <= step_result;
    end

    // A word part way through its writes is always held
    a_phase_held: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_START) |-> hold_valid_reg)
        else $error("sequencer mid-word with no word held");

    // Write position stays within the buffer
    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.write_position >= WP_RESET) && (st_reg.write_position <= TABLE_LIMIT))
        else $error("write position out of range");

    // With no block open the builder sits at its reset position
    a_closed_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg.block_open |-> (st_reg.write_position == WP_RESET)
                               && (st_reg.block_start == '0))
        else $error("closed table not at reset position");

    // An open block never starts beyond the write position
    a_block_order: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.block_open |-> (st_reg.write_position >= {1'b0, st_reg.block_start}))
        else $error("block start beyond write position");

endmodule

`default_nettype wire

// File: hdl/rtb_step.sv
// One sequencer step: picks the next buffer write for the word in hand and the next state.
`timescale 1ns / 1ps
`default_nettype none

module rtb_step
    import rtb_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
)
(
    input  tbl_state_t  state,
    input  phase_t      phase,
    input  in_word_t    item,
    input  logic [31:0] image_base_low,
    input  logic        wide_mode,
    output tbl_state_t  state_next,
    output out_word_t   result,
    output step_ctl_t   ctl
);

    localparam logic [17:0] TABLE_LIMIT = 18'(TABLE_BYTES);

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_PAD,
        STEP_PATCH,
        STEP_HDR,
        STEP_ENTRY
    } step_t;

    // Position advance, saturating at the buffer size
    function automatic logic [16:0] advance_pos(input logic [16:0] pos, input logic [3:0] by);
        logic [17:0] sum;
        sum = {1'b0, pos} + {14'b0, by};
        return (sum > TABLE_LIMIT) ? TABLE_LIMIT[16:0] : sum[16:0];
    endfunction

    // Write runs past the end of the buffer
    function automatic logic past_end(input logic [17:0] off, input logic [3:0] len);
        logic [17:0] end_pos;
        end_pos = off + {14'b0, len};
        return end_pos > TABLE_LIMIT;
    endfunction

    logic [51:0] page;
    logic        page_diff;
    logic [16:0] span;
    logic        misaligned;
    logic        is_add;
    logic [31:0] rva;
    logic [15:0] tag;
    logic [17:0] wp_ext;
    logic [17:0] patch_off;
    logic [16:0] wp_entry;
    logic [16:0] wp_header;
    step_t       step;

    assign page       = item.target_address[63:12];
    assign page_diff  = (page != state.open_page);
    assign span       = state.write_position - {1'b0, state.block_start};
    assign misaligned = (span[1:0] != 2'b00);
    assign is_add     = (item.operation == OP_ADD);
    assign rva        = {item.target_address[31:12], 12'b0} - image_base_low;
    assign tag        = wide_mode ? TAG_WIDE : TAG_NARROW;
    assign wp_ext     = {1'b0, state.write_position};
    assign patch_off  = {2'b0, state.block_start} + {14'b0, LEN_DWORD};
    assign wp_entry   = advance_pos(state.write_position, LEN_ENTRY);
    assign wp_header  = advance_pos(state.write_position, LEN_HEADER);

    // Choose the step
    always_comb
    begin
        step = STEP_NONE;
        case (phase)
            PH_START:
            begin
                if (is_add)
                begin
                    if (!state.block_open)
                        step = STEP_HDR;
                    else if (page_diff)
                        step = misaligned ? STEP_PAD : STEP_PATCH;
                    else
                        step = STEP_ENTRY;
                end
                else if (state.block_open)
                begin
                    step = misaligned ? STEP_PAD : STEP_PATCH;
                end
            end
            PH_PATCH: step = STEP_PATCH;
            PH_HDR:   step = STEP_HDR;
            PH_ENTRY: step = STEP_ENTRY;
            default:  step = STEP_NONE;
        endcase
    end

    // Result word and next state for the chosen step
    always_comb
    begin
        state_next     = state;
        result         = '0;
        ctl.has_result = 1'b1;
        ctl.done       = 1'b0;
        ctl.phase_next = PH_START;
        case (step)
            STEP_PAD:
            begin
                state_next.write_position = wp_entry;
                result.write_offset = state.write_position[15:0];
                result.write_data   = '0;
                result.write_wide   = 1'b0;
                result.used_bytes   = wp_entry;
                result.overflow     = past_end(wp_ext, LEN_ENTRY);
                ctl.phase_next      = PH_PATCH;
            end
            STEP_PATCH:
            begin
                result.write_offset = patch_off[15:0];
                result.write_data   = {15'b0, span};
                result.write_wide   = 1'b1;
                result.used_bytes   = state.write_position;
                result.overflow     = past_end(patch_off, LEN_DWORD);
                result.last         = !is_add;
                if (is_add)
                begin
                    ctl.phase_next = PH_HDR;
                end
                else
                begin
                    // finish: table closed, back to the reset state
                    ctl.done                  = 1'b1;
                    state_next.open_page      = '0;
                    state_next.block_open     = 1'b0;
                    state_next.block_start    = '0;
                    state_next.write_position = WP_RESET;
                end
            end
            STEP_HDR:
            begin
                state_next.open_page  = page;
                state_next.block_open = 1'b1;
                result.write_data     = rva;
                result.write_wide     = 1'b1;
                ctl.phase_next        = PH_ENTRY;
                if (!state.block_open)
                begin
                    // first block: header space already reserved
                    result.write_offset = state.block_start;
                    result.used_bytes   = state.write_position;
                    result.overflow     = past_end({2'b0, state.block_start}, LEN_DWORD);
                end
                else
                begin
                    state_next.block_start    = state.write_position[16] ? START_LIMIT
                                                : state.write_position[15:0];
                    state_next.write_position = wp_header;
                    result.write_offset       = state.write_position[15:0];
                    result.used_bytes         = wp_header;
                    result.overflow           = past_end(wp_ext, LEN_DWORD);
                end
            end
            STEP_ENTRY:
            begin
                state_next.write_position = wp_entry;
                result.write_offset = state.write_position[15:0];
                result.write_data   = {16'b0, tag | {4'b0, item.target_address[11:0]}};
                result.write_wide   = 1'b0;
                result.used_bytes   = wp_entry;
                result.overflow     = past_end(wp_ext, LEN_ENTRY);
                result.last         = 1'b1;
                ctl.done            = 1'b1;
            end
            default:
            begin
                // finish with nothing open: no write, state back to reset
                ctl.has_result            = 1'b0;
                ctl.done                  = 1'b1;
                state_next.open_page      = '0;
                state_next.block_open     = 1'b0;
                state_next.block_start    = '0;
                state_next.write_position = WP_RESET;
            end
        endcase
    end

endmodule

`default_nettype wire
